// File: rtl/kde_pkg.sv
package kde_pkg;

    // Matrix size and derived key count
    localparam int ROWS    = 4;
    localparam int COLS    = 4;
    localparam int NKEYS   = ROWS * COLS;
    localparam int RAW_W   = 16;
    localparam int QUERY_W = 4;

    // Counter and register widths
    localparam int CNT_W  = 8;
    localparam int EVT_W  = 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register map (word index)
    localparam logic [APB_AW-3:0] REG_DEBOUNCE_COUNT = '0;
    localparam logic [CNT_W-1:0]  DEBOUNCE_RESET     = CNT_W'(3);

    // Event codes
    localparam logic [EVT_W-1:0] EVT_NONE       = EVT_W'(0);
    localparam logic [EVT_W-1:0] EVT_UP         = EVT_W'(1);
    localparam logic [EVT_W-1:0] EVT_DOWN       = EVT_W'(2);
    localparam logic [EVT_W-1:0] EVT_START_STOP = EVT_W'(3);
    localparam logic [EVT_W-1:0] EVT_DIRECTION  = EVT_W'(4);

    // Per-key status passed from each lane to the merge stage
    typedef struct packed {
        logic next_stable;
        logic press;
    } t_lane_stat;

    // Fixed key-to-event map: column 0 of the first four rows
    function automatic logic [EVT_W-1:0] event_of(input int k);
        logic [EVT_W-1:0] evt;
        evt = EVT_NONE;
        if ((k % COLS) == 0) begin
            case (k / COLS)
                0:       evt = EVT_UP;
                1:       evt = EVT_DOWN;
                2:       evt = EVT_START_STOP;
                3:       evt = EVT_DIRECTION;
                default: evt = EVT_NONE;
            endcase
        end
        return evt;
    endfunction

endpackage

// File: rtl/kde_ifs.sv
// Scan request channel
interface kde_in_if
    import kde_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RAW_W-1:0]   raw_keys;
    logic [QUERY_W-1:0] query_key;

    modport source (output valid, output raw_keys, output query_key, input ready);
    modport sink   (input valid, input raw_keys, input query_key, output ready);
endinterface

// Result channel
interface kde_out_if
    import kde_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [EVT_W-1:0] key_event;
    logic             query_held;

    modport source (output valid, output key_event, output query_held, input ready);
    modport sink   (input valid, input key_event, input query_held, output ready);
endinterface

// File: rtl/kde_lane.sv
module kde_lane
    import kde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_raw,
    input  logic [CNT_W-1:0] i_debounce_count,
    output t_lane_stat       o_stat
);

    logic             r_stable;
    logic [CNT_W-1:0] r_cnt;
    logic             n_stable;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic             press;

    // Count differing scans, saturating; take the raw value once the count is met
    always_comb begin
        cnt_inc  = (r_cnt == {CNT_W{1'b1}}) ? r_cnt : r_cnt + CNT_W'(1);
        n_stable = r_stable;
        n_cnt    = '0;
        press    = 1'b0;
        if (i_raw != r_stable) begin
            if (cnt_inc >= i_debounce_count) begin
                n_stable = i_raw;
                press    = i_raw;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    // Advance the key state on each accepted scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_cnt    <= '0;
        end else if (i_step) begin
            r_stable <= n_stable;
            r_cnt    <= n_cnt;
        end
    end

    assign o_stat.next_stable = n_stable;
    assign o_stat.press       = press;

endmodule

// File: rtl/kde_merge.sv
module kde_merge
    import kde_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_taken,
    input  t_lane_stat         i_stat [NKEYS],
    input  logic [QUERY_W-1:0] i_query_key,
    output logic               o_valid,
    output logic [EVT_W-1:0]   o_key_event,
    output logic               o_query_held
);

    logic             r_valid;
    logic [EVT_W-1:0] r_event;
    logic             r_held;
    logic [EVT_W-1:0] evt;
    logic             held;

    // Lowest newly pressed key with a mapped event wins
    always_comb begin
        evt = EVT_NONE;
        for (int k = NKEYS - 1; k >= 0; k--) begin
            if (i_stat[k].press && (event_of(k) != EVT_NONE)) begin
                evt = event_of(k);
            end
        end
    end

    // Select the queried key's state after this scan; out of range reads released
    always_comb begin
        held = 1'b0;
        for (int k = 0; k < NKEYS; k++) begin
            if (32'(i_query_key) == 32'(k)) begin
                held = i_stat[k].next_stable;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event <= evt;
            r_held  <= held;
        end
    end

    assign o_valid      = r_valid;
    assign o_key_event  = r_event;
    assign o_query_held = r_held;

endmodule

// File: rtl/keypad_debounce_event.sv
// Debounces a 4x4 key matrix one scan per request and reports a key event and the
// debounced state of one queried key for each scan. All sixteen key lanes update in
// parallel and the merge stage registers the result, so a new scan is taken every
// cycle while the result register is free or being taken.
// A key's debounced state follows its raw bit after debounce_count consecutive
// differing scans (APB register at byte address 0, reset value 3); a newly pressed
// key in column 0 of rows 0 to 3 gives up, down, start_stop or direction, the lowest
// such key winning. Releases give no event.
module keypad_debounce_event
    import kde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    kde_in_if.sink            i_scan,
    kde_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CNT_W-1:0] r_debounce_count;
    logic             step;
    logic             out_valid;
    logic             reg_sel;
    t_lane_stat       stat [NKEYS];

    // Configuration register
    assign reg_sel = (paddr[APB_AW-1:2] == REG_DEBOUNCE_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_count <= DEBOUNCE_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_debounce_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(APB_DW - CNT_W){1'b0}}, r_debounce_count} : '0;

    // Accept a scan whenever the result register is empty or being drained
    assign i_scan.ready = !out_valid || o_result.ready;
    assign step         = i_scan.valid && i_scan.ready;

    // One debouncer lane per key; keys beyond the raw word read released
    for (genvar k = 0; k < NKEYS; k++) begin : g_lane
        logic raw_bit;
        if (k < RAW_W) begin : g_raw
            assign raw_bit = i_scan.raw_keys[k];
        end else begin : g_none
            assign raw_bit = 1'b0;
        end
        kde_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_step           (step),
            .i_raw            (raw_bit),
            .i_debounce_count (r_debounce_count),
            .o_stat           (stat[k])
        );
    end

    // Merge lane results into the registered output
    kde_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (step),
        .i_taken      (o_result.ready),
        .i_stat       (stat),
        .i_query_key  (i_scan.query_key),
        .o_valid      (out_valid),
        .o_key_event  (o_result.key_event),
        .o_query_held (o_result.query_held)
    );

    assign o_result.valid = out_valid;

endmodule
